@@ hw/rtl/gjk_pkg.sv @@
// Package with the opcodes, status codes and widths of the GJK intersection unit.
package gjk_pkg;
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_LOAD_P = 2'd1,
      OP_LOAD_Q = 2'd2,
      OP_RUN    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DISJOINT  = 2'd0,
      ST_INTERSECT = 2'd1,
      ST_LIMIT     = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   localparam int CFG_BITS = 8;
   localparam logic [CFG_BITS-1:0] LIMIT_RESET = 8'd64;
   localparam int ITER_BITS = 8;
endpackage

@@ hw/rtl/gjk_ifc.sv @@
// Valid/ready channel interfaces for requests, responses and the limit register.
interface gjk_req_ifc #(parameter int COORD_BITS = 12);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   opcode;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;
   modport source (output valid, opcode, coord_x, coord_y, input ready);
   modport sink (input valid, opcode, coord_x, coord_y, output ready);
endinterface

interface gjk_rsp_ifc;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] iterations_used;
   modport source (output valid, status, iterations_used, input ready);
   modport sink (input valid, status, iterations_used, output ready);
endinterface

interface gjk_csr_ifc;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/gjk_mac.sv @@
// Shared signed multiply-accumulate unit with a registered accumulator.
module gjk_mac
   import gjk_pkg::*;
#(
   parameter int A_BITS = 18,
   parameter int B_BITS = 18,
   parameter int ACC_BITS = 48
) (
   input  logic                       clock,
   input  logic signed [A_BITS-1:0]   op_a,
   input  logic signed [B_BITS-1:0]   op_b,
   input  logic                       acc_clear,
   input  logic                       acc_sub,
   output logic signed [ACC_BITS-1:0] acc
);
   logic signed [A_BITS+B_BITS-1:0] prod;
   logic signed [ACC_BITS-1:0]      acc_ff;
   logic signed [ACC_BITS-1:0]      acc_in;
   logic signed [ACC_BITS-1:0]      base;

   always_comb begin
      prod = op_a * op_b;
      base = acc_clear ? '0 : acc_ff;
      if (acc_sub) begin
         acc_in = base - ACC_BITS'(prod);
      end else begin
         acc_in = base + ACC_BITS'(prod);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_in;
endmodule

@@ hw/rtl/gjk_convex_polygon_intersect_unit.sv @@
// Top level of the 2D GJK convex polygon intersection unit.
//
//  channel  dir  payload                               accepted when
//  req      in   opcode, coord_x, coord_y              req_valid & req_ready
//  rsp      out  status, iterations_used               rsp_valid & rsp_ready
//  csr      in   iteration_limit (8 bits)              csr_valid & csr_ready
//
// Clear and load items take effect when accepted; a run against an empty polygon
// goes through S_RESP before its result is shown. A support search visits each
// P vertex, then each Q vertex: one shared multiplier computes every dot and cross
// product, so each vertex costs a read, an x product and a y product. A run is
// accepted and makes one initial search; each iteration adds a search, the origin
// test (disjoint exit), then a line or a triangle step; S_RESP posts the result.
// Reset is synchronous and active high; it empties both polygons and sets the
// limit to 64. The result waits in an output register and the block takes no
// item until it is taken.
module gjk_convex_polygon_intersect_unit
   import gjk_pkg::*;
#(
   parameter int MAX_VERTS = 64,
   parameter int COORD_BITS = 12
) (
   input  logic         clock,
   input  logic         reset,
   gjk_req_ifc.sink     req,
   gjk_rsp_ifc.source   rsp,
   gjk_csr_ifc.sink     csr
);
   // Minkowski points need one extra bit, edges two more; directions from
   // normals are edge-wide, the first direction is point-wide.
   localparam int PW = COORD_BITS + 1;
   localparam int EW = COORD_BITS + 2;
   localparam int MW = EW + 2;
   localparam int AW = 2 * MW + 4;
   localparam int IW = $clog2(MAX_VERTS);
   localparam int CW = $clog2(MAX_VERTS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SUP_INIT, S_SUP_RD, S_SUP_X, S_SUP_Y, S_SUP_DONE,
      S_TEST, S_TEST_Y, S_CROSS1, S_CROSS2, S_N1A, S_N1B, S_N2A, S_N2B,
      S_RESP
   } state_type;

   state_type state_ff;
   logic [2*COORD_BITS-1:0] p_mem [MAX_VERTS];
   logic [2*COORD_BITS-1:0] q_mem [MAX_VERTS];
   logic [2*COORD_BITS-1:0] p_rd_ff, q_rd_ff;
   logic [CW-1:0] count_p_ff, count_q_ff;
   logic [CW-1:0] idx_ff;
   logic          side_ff;
   logic [7:0]    limit_ff;
   logic [7:0]    iters_ff;
   logic          first_ff;
   logic signed [MW-1:0] dx_ff, dy_ff;
   logic signed [AW-1:0] best_dot_ff;
   logic                 best_valid_ff;
   logic signed [COORD_BITS-1:0] px_ff, py_ff, qx_ff, qy_ff;
   logic signed [PW-1:0] sx_ff [3];
   logic signed [PW-1:0] sy_ff [3];
   logic [1:0]           slen_ff;
   logic signed [PW-1:0] ax_ff, ay_ff;
   logic signed [1:0]    sgn_ff;
   logic [1:0]           status_ff;
   logic                 rsp_valid_ff;

   logic signed [MW-1:0] mac_a, mac_b;
   logic                 mac_clear, mac_sub;
   logic signed [AW-1:0] mac_acc;

   gjk_mac #(.A_BITS(MW), .B_BITS(MW), .ACC_BITS(AW)) u_mac (
      .clock(clock), .op_a(mac_a), .op_b(mac_b),
      .acc_clear(mac_clear), .acc_sub(mac_sub), .acc(mac_acc)
   );

   logic signed [COORD_BITS-1:0] vx, vy;
   logic signed [EW-1:0] abx, aby, acx, acy, ex, ey;
   logic [CW-1:0] cur_cnt;
   logic signed [1:0] acc_sgn;

   always_comb begin
      vx = side_ff ? q_rd_ff[2*COORD_BITS-1:COORD_BITS] : p_rd_ff[2*COORD_BITS-1:COORD_BITS];
      vy = side_ff ? q_rd_ff[COORD_BITS-1:0] : p_rd_ff[COORD_BITS-1:0];
      cur_cnt = side_ff ? count_q_ff : count_p_ff;
      abx = EW'(sx_ff[1]) - EW'(ax_ff);
      aby = EW'(sy_ff[1]) - EW'(ay_ff);
      acx = EW'(sx_ff[0]) - EW'(ax_ff);
      acy = EW'(sy_ff[0]) - EW'(ay_ff);
      ex  = EW'(sx_ff[0]) - EW'(ax_ff);
      ey  = EW'(sy_ff[0]) - EW'(ay_ff);
      acc_sgn = (mac_acc > 0) ? 2'sd1 : ((mac_acc < 0) ? -2'sd1 : 2'sd0);
      mac_a = '0;
      mac_b = '0;
      mac_clear = 1'b1;
      mac_sub = 1'b0;
      unique case (state_ff)
         S_SUP_X: begin
            mac_a = MW'(vx);
            mac_b = side_ff ? MW'(-dx_ff) : dx_ff;
         end
         S_SUP_Y: begin
            mac_a = MW'(vy);
            mac_b = side_ff ? MW'(-dy_ff) : dy_ff;
            mac_clear = 1'b0;
         end
         S_TEST: begin
            mac_a = MW'(ax_ff);
            mac_b = dx_ff;
         end
         S_TEST_Y: begin
            mac_a = MW'(ay_ff);
            mac_b = dy_ff;
            mac_clear = 1'b0;
         end
         S_CROSS1: begin
            // line: aox*aby ; triangle: acx*aby
            mac_a = (slen_ff == 2'd3) ? MW'(acx) : MW'(-ax_ff);
            mac_b = (slen_ff == 2'd3) ? MW'(aby) : MW'(ey);
         end
         S_CROSS2: begin
            mac_a = (slen_ff == 2'd3) ? MW'(acy) : MW'(-ay_ff);
            mac_b = (slen_ff == 2'd3) ? MW'(abx) : MW'(ex);
            mac_clear = 1'b0;
            mac_sub = 1'b1;
         end
         S_N1A: begin
            // abn . ao = s*(aby*ax - abx*ay)
            mac_a = MW'(aby);
            mac_b = MW'(ax_ff);
         end
         S_N1B: begin
            mac_a = MW'(abx);
            mac_b = MW'(ay_ff);
            mac_clear = 1'b0;
            mac_sub = 1'b1;
         end
         S_N2A: begin
            // acn . ao = s*(acx*ay - acy*ax)
            mac_a = MW'(acx);
            mac_b = MW'(ay_ff);
         end
         S_N2B: begin
            mac_a = MW'(acy);
            mac_b = MW'(ax_ff);
            mac_clear = 1'b0;
            mac_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = status_ff;
   assign rsp.iterations_used = iters_ff;

   logic req_fire;
   assign req_fire = req.valid && req.ready;

   // A run that has used up its iterations without a verdict reports the limit.
   logic limit_hit;
   assign limit_hit = (iters_ff == limit_ff);

   // Vertex stores with one registered read port each.
   always_ff @(posedge clock) begin
      if (req_fire && req.opcode == OP_LOAD_P && count_p_ff < CW'(MAX_VERTS)) begin
         p_mem[count_p_ff[IW-1:0]] <= {req.coord_x, req.coord_y};
      end
      if (req_fire && req.opcode == OP_LOAD_Q && count_q_ff < CW'(MAX_VERTS)) begin
         q_mem[count_q_ff[IW-1:0]] <= {req.coord_x, req.coord_y};
      end
      p_rd_ff <= p_mem[idx_ff[IW-1:0]];
      q_rd_ff <= q_mem[idx_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_p_ff <= '0;
         count_q_ff <= '0;
         limit_ff <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            limit_ff <= csr.data;
         end
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  unique case (opcode_type'(req.opcode))
                     OP_CLEAR: begin
                        count_p_ff <= '0;
                        count_q_ff <= '0;
                     end
                     OP_LOAD_P: begin
                        if (count_p_ff < CW'(MAX_VERTS)) count_p_ff <= count_p_ff + 1'b1;
                     end
                     OP_LOAD_Q: begin
                        if (count_q_ff < CW'(MAX_VERTS)) count_q_ff <= count_q_ff + 1'b1;
                     end
                     OP_RUN: begin
                        iters_ff <= '0;
                        if (count_p_ff == '0 || count_q_ff == '0) begin
                           status_ff <= ST_EMPTY;
                           state_ff <= S_RESP;
                        end else begin
                           dx_ff <= MW'(req.coord_x);
                           dy_ff <= MW'(req.coord_y);
                           first_ff <= 1'b1;
                           state_ff <= S_SUP_INIT;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_SUP_INIT: begin
               side_ff <= 1'b0;
               idx_ff <= '0;
               best_valid_ff <= 1'b0;
               state_ff <= S_SUP_RD;
            end
            S_SUP_RD: begin
               state_ff <= S_SUP_X;
            end
            S_SUP_X: begin
               state_ff <= S_SUP_Y;
            end
            S_SUP_Y: begin
               // Strictly greater keeps the earliest vertex on ties.
               if (!best_valid_ff || mac_acc > best_dot_ff) begin
                  best_dot_ff <= mac_acc;
                  best_valid_ff <= 1'b1;
                  if (side_ff) begin
                     qx_ff <= vx;
                     qy_ff <= vy;
                  end else begin
                     px_ff <= vx;
                     py_ff <= vy;
                  end
               end
               if (idx_ff + 1'b1 < cur_cnt) begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= S_SUP_RD;
               end else if (!side_ff) begin
                  side_ff <= 1'b1;
                  idx_ff <= '0;
                  best_valid_ff <= 1'b0;
                  state_ff <= S_SUP_RD;
               end else begin
                  state_ff <= S_SUP_DONE;
               end
            end
            S_SUP_DONE: begin
               ax_ff <= PW'(px_ff) - PW'(qx_ff);
               ay_ff <= PW'(py_ff) - PW'(qy_ff);
               if (first_ff) begin
                  first_ff <= 1'b0;
                  sx_ff[0] <= PW'(px_ff) - PW'(qx_ff);
                  sy_ff[0] <= PW'(py_ff) - PW'(qy_ff);
                  slen_ff <= 2'd1;
                  dx_ff <= MW'(PW'(qx_ff) - PW'(px_ff));
                  dy_ff <= MW'(PW'(qy_ff) - PW'(py_ff));
                  if (limit_ff == '0) begin
                     status_ff <= ST_LIMIT;
                     state_ff <= S_RESP;
                  end else begin
                     iters_ff <= 8'd1;
                     state_ff <= S_SUP_INIT;
                  end
               end else begin
                  state_ff <= S_TEST;
               end
            end
            S_TEST: begin
               state_ff <= S_TEST_Y;
            end
            S_TEST_Y: begin
               if (mac_acc < 0) begin
                  status_ff <= ST_DISJOINT;
                  state_ff <= S_RESP;
               end else begin
                  if (slen_ff != 2'd3) begin
                     sx_ff[slen_ff] <= ax_ff;
                     sy_ff[slen_ff] <= ay_ff;
                     slen_ff <= slen_ff + 1'b1;
                  end
                  state_ff <= S_CROSS1;
               end
            end
            S_CROSS1: begin
               state_ff <= S_CROSS2;
            end
            S_CROSS2: begin
               if (slen_ff == 2'd3) begin
                  sgn_ff <= acc_sgn;
                  state_ff <= S_N1A;
               end else begin
                  // line case: d = s*(aby, -abx), ab = s0 - a
                  dx_ff <= acc_sgn[1] ? MW'(-ey) : (acc_sgn[0] ? MW'(ey) : '0);
                  dy_ff <= acc_sgn[1] ? MW'(ex) : (acc_sgn[0] ? MW'(-ex) : '0);
                  if (limit_hit) begin
                     status_ff <= ST_LIMIT;
                     state_ff <= S_RESP;
                  end else begin
                     iters_ff <= iters_ff + 8'd1;
                     state_ff <= S_SUP_INIT;
                  end
               end
            end
            S_N1A: begin
               state_ff <= S_N1B;
            end
            S_N1B: begin
               if ((sgn_ff == 2'sd1 && mac_acc > 0) || (sgn_ff == -2'sd1 && mac_acc < 0)) begin
                  sx_ff[0] <= sx_ff[1];
                  sy_ff[0] <= sy_ff[1];
                  sx_ff[1] <= ax_ff;
                  sy_ff[1] <= ay_ff;
                  slen_ff <= 2'd2;
                  dx_ff <= sgn_ff[1] ? MW'(aby) : MW'(-aby);
                  dy_ff <= sgn_ff[1] ? MW'(-abx) : MW'(abx);
                  if (limit_hit) begin
                     status_ff <= ST_LIMIT;
                     state_ff <= S_RESP;
                  end else begin
                     iters_ff <= iters_ff + 8'd1;
                     state_ff <= S_SUP_INIT;
                  end
               end else begin
                  state_ff <= S_N2A;
               end
            end
            S_N2A: begin
               state_ff <= S_N2B;
            end
            S_N2B: begin
               if ((sgn_ff == 2'sd1 && mac_acc > 0) || (sgn_ff == -2'sd1 && mac_acc < 0)) begin
                  sx_ff[1] <= ax_ff;
                  sy_ff[1] <= ay_ff;
                  slen_ff <= 2'd2;
                  dx_ff <= sgn_ff[1] ? MW'(-acy) : MW'(acy);
                  dy_ff <= sgn_ff[1] ? MW'(acx) : MW'(-acx);
                  if (limit_hit) begin
                     status_ff <= ST_LIMIT;
                     state_ff <= S_RESP;
                  end else begin
                     iters_ff <= iters_ff + 8'd1;
                     state_ff <= S_SUP_INIT;
                  end
               end else begin
                  status_ff <= ST_INTERSECT;
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   ap_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE)
      else $error("ready outside idle");
   ap_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff)
      else $error("response dropped");
   ap_iter_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> iters_ff <= limit_ff || status_ff == ST_EMPTY)
      else $error("iterations beyond limit");
endmodule
